FILE: rtl/plg_pkg.sv
// Shared types, constants and register codes for the pulse-counting laser gate.
`default_nettype none
package plg_pkg;

    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned INDEX_W  = 8;
    localparam int unsigned TARGET_W = COUNT_W + INDEX_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned MID_DEPTH_DEF = 4;
    localparam int unsigned OUT_DEPTH_DEF = 4;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNKS_PER_WINDOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISCHARGE_ENABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISCHARGE_CHUNKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_CHUNK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRACKING_ENABLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TRACKING_LIMIT    = 3'd6;

    localparam logic [SAMPLE_W-1:0] RST_PULSE_THRESHOLD   = 12'd4000;
    localparam logic [INDEX_W-1:0]  RST_CHUNKS_PER_WINDOW = 8'd5;
    localparam logic                RST_DISCHARGE_ENABLE  = 1'b1;
    localparam logic [INDEX_W-1:0]  RST_DISCHARGE_CHUNKS  = 8'd1;
    localparam logic [COUNT_W-1:0]  RST_PULSES_PER_CHUNK  = 16'd30;
    localparam logic                RST_TRACKING_ENABLE   = 1'b1;
    localparam logic [COUNT_W-1:0]  RST_TRACKING_LIMIT    = 16'd10;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [INDEX_W-1:0]  chunks_per_window;
        logic                discharge_enable;
        logic [INDEX_W-1:0]  discharge_chunks;
        logic                tracking_enable;
        logic [COUNT_W-1:0]  tracking_limit;
        logic [TARGET_W-1:0] target;
    } t_back_cfg;

    typedef struct packed {
        logic [COUNT_W-1:0] chunk_pulses;
        logic               window_done;
        logic [COUNT_W-1:0] window_pulses;
        logic               laser_enable;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);

endpackage
`default_nettype wire

FILE: rtl/plg_fifo.sv
// Small register queue used between the front, the back and the result ports.
`default_nettype none
module plg_fifo
    import plg_pkg::*;
#(
    parameter int unsigned WIDTH = COUNT_W,
    parameter int unsigned DEPTH = MID_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/plg_front.sv
// Front end: threshold runs in the sample stream and counts pulses per chunk.
`default_nettype none
module plg_front
    import plg_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [SAMPLE_W-1:0] i_threshold,
    input  wire logic                i_accept,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic                i_last_of_chunk,
    output logic                     o_chunk_push,
    output logic [COUNT_W-1:0]       o_chunk_pulses
);

    logic               r_in_run;
    logic [COUNT_W-1:0] r_chunk_count;
    logic               n_in_run;
    logic [COUNT_W-1:0] n_chunk_count;
    logic               above;

    assign above = (i_sample > i_threshold);

    always_comb begin
        n_in_run      = above;
        n_chunk_count = r_chunk_count;
        if (!above && r_in_run && (r_chunk_count != COUNT_MAX)) begin
            n_chunk_count = r_chunk_count + 1'b1;
        end
    end

    assign o_chunk_push   = i_accept && i_last_of_chunk;
    assign o_chunk_pulses = n_chunk_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run      <= 1'b0;
            r_chunk_count <= '0;
        end else if (i_accept) begin
            if (i_last_of_chunk) begin
                r_in_run      <= 1'b0;
                r_chunk_count <= '0;
            end else begin
                r_in_run      <= n_in_run;
                r_chunk_count <= n_chunk_count;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/plg_back.sv
// Back end: window totals, the discharge decision and the laser state per chunk.
`default_nettype none
module plg_back
    import plg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_back_cfg          i_cfg,
    input  wire logic               i_chunk_empty,
    input  wire logic [COUNT_W-1:0] i_chunk_pulses,
    output logic                    o_chunk_pop,
    input  wire logic               i_result_full,
    output logic                    o_result_push,
    output t_result                 o_result
);

    logic [COUNT_W-1:0] r_window_total;
    logic [INDEX_W-1:0] r_chunk_index;
    logic [COUNT_W-1:0] r_tracking_count;
    logic               r_laser_state;

    logic [COUNT_W-1:0] n_window_total;
    logic [INDEX_W-1:0] n_chunk_index;
    logic [COUNT_W-1:0] n_tracking_count;
    logic               n_laser_state;

    logic [COUNT_W:0]   total_sum;
    logic [COUNT_W-1:0] total_sat;
    logic [INDEX_W-1:0] index_inc;
    logic [COUNT_W-1:0] track_inc;
    logic               target_met;
    logic               window_end;
    logic               step;

    assign step          = !i_chunk_empty && !i_result_full;
    assign o_chunk_pop   = step;
    assign o_result_push = step;

    always_comb begin
        total_sum  = {1'b0, r_window_total} + {1'b0, i_chunk_pulses};
        total_sat  = total_sum[COUNT_W] ? COUNT_MAX : total_sum[COUNT_W-1:0];
        index_inc  = r_chunk_index + 1'b1;
        track_inc  = (r_tracking_count == COUNT_MAX) ? COUNT_MAX
                                                     : r_tracking_count + 1'b1;
        target_met = ({{INDEX_W{1'b0}}, total_sat} >= i_cfg.target);
        window_end = (index_inc == i_cfg.chunks_per_window);

        n_window_total   = total_sat;
        n_chunk_index    = index_inc;
        n_tracking_count = r_tracking_count;
        n_laser_state    = r_laser_state;

        if (i_cfg.discharge_enable && (index_inc == i_cfg.discharge_chunks)) begin
            n_tracking_count = track_inc;
            if (target_met) begin
                if (i_cfg.tracking_enable) begin
                    n_tracking_count = '0;
                end
                n_laser_state = 1'b1;
            end else if (i_cfg.tracking_enable) begin
                if (i_cfg.tracking_limit < track_inc) begin
                    n_laser_state = 1'b0;
                end
            end else begin
                n_laser_state = 1'b0;
            end
        end

        if (window_end) begin
            n_window_total = '0;
            n_chunk_index  = '0;
            n_laser_state  = 1'b1;
        end

        o_result.chunk_pulses  = i_chunk_pulses;
        o_result.window_done   = window_end;
        o_result.window_pulses = window_end ? total_sat : '0;
        o_result.laser_enable  = n_laser_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_total   <= '0;
            r_chunk_index    <= '0;
            r_tracking_count <= '0;
            r_laser_state    <= 1'b1;
        end else if (step) begin
            r_window_total   <= n_window_total;
            r_chunk_index    <= n_chunk_index;
            r_tracking_count <= n_tracking_count;
            r_laser_state    <= n_laser_state;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/pulse_count_laser_gate.sv
// Throughput: one sample per cycle while full is low; the back end retires one chunk
// per cycle while the result queue is not full.
// full rises only when the chunk queue between front and back end is full.
// Reset is synchronous and active low: counters clear, the laser is on,
// and the configuration registers return to their default values.
`default_nettype none
module pulse_count_laser_gate
    import plg_pkg::*;
#(
    parameter int unsigned MID_DEPTH = MID_DEPTH_DEF,
    parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [SAMPLE_W-1:0]   i_sample,
    input  wire logic                  i_last_of_chunk,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [COUNT_W-1:0]         o_chunk_pulses,
    output logic                       o_window_done,
    output logic [COUNT_W-1:0]         o_window_pulses,
    output logic                       o_laser_enable,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [SAMPLE_W-1:0] r_pulse_threshold;
    logic [INDEX_W-1:0]  r_chunks_per_window;
    logic                r_discharge_enable;
    logic [INDEX_W-1:0]  r_discharge_chunks;
    logic [COUNT_W-1:0]  r_pulses_per_chunk;
    logic                r_tracking_enable;
    logic [COUNT_W-1:0]  r_tracking_limit;
    logic [TARGET_W-1:0] r_target;

    t_back_cfg          back_cfg;
    logic               accept;
    logic               chunk_push;
    logic [COUNT_W-1:0] chunk_in;
    logic [COUNT_W-1:0] chunk_out;
    logic               chunk_empty;
    logic               chunk_pop;
    logic               result_push;
    logic               result_full;
    t_result            result_in;
    t_result            result_out;
    logic [RESULT_W-1:0] result_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_threshold   <= RST_PULSE_THRESHOLD;
            r_chunks_per_window <= RST_CHUNKS_PER_WINDOW;
            r_discharge_enable  <= RST_DISCHARGE_ENABLE;
            r_discharge_chunks  <= RST_DISCHARGE_CHUNKS;
            r_pulses_per_chunk  <= RST_PULSES_PER_CHUNK;
            r_tracking_enable   <= RST_TRACKING_ENABLE;
            r_tracking_limit    <= RST_TRACKING_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PULSE_THRESHOLD:   r_pulse_threshold   <= i_cfg_wdata[SAMPLE_W-1:0];
                REG_CHUNKS_PER_WINDOW: r_chunks_per_window <= i_cfg_wdata[INDEX_W-1:0];
                REG_DISCHARGE_ENABLE:  r_discharge_enable  <= i_cfg_wdata[0];
                REG_DISCHARGE_CHUNKS:  r_discharge_chunks  <= i_cfg_wdata[INDEX_W-1:0];
                REG_PULSES_PER_CHUNK:  r_pulses_per_chunk  <= i_cfg_wdata[COUNT_W-1:0];
                REG_TRACKING_ENABLE:   r_tracking_enable   <= i_cfg_wdata[0];
                REG_TRACKING_LIMIT:    r_tracking_limit    <= i_cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_target <= TARGET_W'(r_pulses_per_chunk) * TARGET_W'(r_discharge_chunks);
    end

    always_comb begin
        back_cfg.chunks_per_window = r_chunks_per_window;
        back_cfg.discharge_enable  = r_discharge_enable;
        back_cfg.discharge_chunks  = r_discharge_chunks;
        back_cfg.tracking_enable   = r_tracking_enable;
        back_cfg.tracking_limit    = r_tracking_limit;
        back_cfg.target            = r_target;
    end

    assign accept = push && !full;

    plg_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_threshold     (r_pulse_threshold),
        .i_accept        (accept),
        .i_sample        (i_sample),
        .i_last_of_chunk (i_last_of_chunk),
        .o_chunk_push    (chunk_push),
        .o_chunk_pulses  (chunk_in)
    );

    plg_fifo #(
        .WIDTH (COUNT_W),
        .DEPTH (MID_DEPTH)
    ) u_chunk_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (chunk_push),
        .i_data  (chunk_in),
        .o_full  (full),
        .i_pop   (chunk_pop),
        .o_data  (chunk_out),
        .o_empty (chunk_empty)
    );

    plg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (back_cfg),
        .i_chunk_empty  (chunk_empty),
        .i_chunk_pulses (chunk_out),
        .o_chunk_pop    (chunk_pop),
        .i_result_full  (result_full),
        .o_result_push  (result_push),
        .o_result       (result_in)
    );

    plg_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (OUT_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (result_push),
        .i_data  (result_in),
        .o_full  (result_full),
        .i_pop   (pop),
        .o_data  (result_bits),
        .o_empty (empty)
    );

    assign result_out      = t_result'(result_bits);
    assign o_chunk_pulses  = result_out.chunk_pulses;
    assign o_window_done   = result_out.window_done;
    assign o_window_pulses = result_out.window_pulses;
    assign o_laser_enable  = result_out.laser_enable;

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for pulse_count_laser_gate: predicts each chunk result and compares it.
`timescale 1ns / 1ps
module testbench;
    import plg_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_REPORTS = 10;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [SAMPLE_W-1:0]   i_sample = '0;
    logic                  i_last_of_chunk = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [COUNT_W-1:0]    o_chunk_pulses;
    logic                  o_window_done;
    logic [COUNT_W-1:0]    o_window_pulses;
    logic                  o_laser_enable;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    pulse_count_laser_gate dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_sample        (i_sample),
        .i_last_of_chunk (i_last_of_chunk),
        .empty           (empty),
        .pop             (pop),
        .o_chunk_pulses  (o_chunk_pulses),
        .o_window_done   (o_window_done),
        .o_window_pulses (o_window_pulses),
        .o_laser_enable  (o_laser_enable),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register mirror.
    logic [SAMPLE_W-1:0] gate_threshold        = RST_PULSE_THRESHOLD;
    logic [INDEX_W-1:0]  gate_chunks_per_window = RST_CHUNKS_PER_WINDOW;
    logic                gate_discharge_en     = RST_DISCHARGE_ENABLE;
    logic [INDEX_W-1:0]  gate_discharge_chunk  = RST_DISCHARGE_CHUNKS;
    logic [COUNT_W-1:0]  gate_pulses_per_chunk = RST_PULSES_PER_CHUNK;
    logic                gate_tracking_en      = RST_TRACKING_ENABLE;
    logic [COUNT_W-1:0]  gate_tracking_limit   = RST_TRACKING_LIMIT;

    // Predicted gate state.
    logic               run_open    = 1'b0;
    logic [COUNT_W-1:0] chunk_tally = '0;
    logic [COUNT_W-1:0] window_sum  = '0;
    logic [INDEX_W-1:0] chunk_pos   = '0;
    logic [COUNT_W-1:0] fail_tally  = '0;
    logic               laser_lit   = 1'b1;

    t_result pending_chunks[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned samples_sent = 0;
    int unsigned chunks_checked = 0;
    int unsigned windows_closed = 0;
    int unsigned laser_off_chunks = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[COUNT_W] ? COUNT_MAX : total[COUNT_W-1:0];
    endfunction

    task automatic track_sample(input logic [SAMPLE_W-1:0] smp, input logic is_last);
        t_result res;
        logic [TARGET_W-1:0] target;
        if (smp > gate_threshold) begin
            run_open = 1'b1;
        end else begin
            if (run_open) chunk_tally = sat_add(chunk_tally, 16'd1);
            run_open = 1'b0;
        end
        if (is_last) begin
            run_open = 1'b0;
            res.chunk_pulses = chunk_tally;
            chunk_tally = '0;
            chunk_pos = chunk_pos + 8'd1;
            window_sum = sat_add(window_sum, res.chunk_pulses);
            if (gate_discharge_en && chunk_pos == gate_discharge_chunk) begin
                target = {{INDEX_W{1'b0}}, gate_pulses_per_chunk}
                       * {{COUNT_W{1'b0}}, gate_discharge_chunk};
                fail_tally = sat_add(fail_tally, 16'd1);
                if ({{INDEX_W{1'b0}}, window_sum} >= target) begin
                    if (gate_tracking_en) fail_tally = '0;
                    laser_lit = 1'b1;
                end else if (gate_tracking_en) begin
                    if (gate_tracking_limit < fail_tally) laser_lit = 1'b0;
                end else begin
                    laser_lit = 1'b0;
                end
            end
            res.window_done = 1'b0;
            res.window_pulses = '0;
            if (chunk_pos == gate_chunks_per_window) begin
                res.window_done = 1'b1;
                res.window_pulses = window_sum;
                window_sum = '0;
                chunk_pos = '0;
                laser_lit = 1'b1;
                windows_closed++;
            end
            res.laser_enable = laser_lit;
            if (!laser_lit) laser_off_chunks++;
            pending_chunks.push_back(res);
        end
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            i_sample <= SAMPLE_W'($urandom_range(4095));
            i_last_of_chunk <= 1'($urandom_range(1));
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_sample <= smp;
        i_last_of_chunk <= is_last;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        track_sample(smp, is_last);
        samples_sent++;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_chunks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            REG_PULSE_THRESHOLD:   gate_threshold = data[SAMPLE_W-1:0];
            REG_CHUNKS_PER_WINDOW: gate_chunks_per_window = data[INDEX_W-1:0];
            REG_DISCHARGE_ENABLE:  gate_discharge_en = data[0];
            REG_DISCHARGE_CHUNKS:  gate_discharge_chunk = data[INDEX_W-1:0];
            REG_PULSES_PER_CHUNK:  gate_pulses_per_chunk = data[COUNT_W-1:0];
            REG_TRACKING_ENABLE:   gate_tracking_en = data[0];
            REG_TRACKING_LIMIT:    gate_tracking_limit = data[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [SAMPLE_W-1:0] thr, input logic [INDEX_W-1:0] cpw,
                                input logic dis_en, input logic [INDEX_W-1:0] dch,
                                input logic [COUNT_W-1:0] ppc, input logic trk_en,
                                input logic [COUNT_W-1:0] tlim);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        wait_idle();
        cfg_write(REG_UNUSED, junk);
        cfg_write(REG_PULSE_THRESHOLD, {junk[15:12], thr});
        cfg_write(REG_CHUNKS_PER_WINDOW, {junk[15:8], cpw});
        cfg_write(REG_DISCHARGE_ENABLE, {junk[15:1], dis_en});
        cfg_write(REG_DISCHARGE_CHUNKS, {junk[15:8], dch});
        cfg_write(REG_PULSES_PER_CHUNK, ppc);
        cfg_write(REG_TRACKING_ENABLE, {junk[15:1], trk_en});
        cfg_write(REG_TRACKING_LIMIT, tlim);
        i_cfg_we <= 1'b0;
    endtask

    // Closes one-sample chunks until the next chunk starts a fresh window.
    task automatic align_window();
        while (chunk_pos != 0) send_sample('0, 1'b1);
    endtask

    function automatic logic [SAMPLE_W-1:0] sample_level(input bit above);
        if ($urandom_range(9) == 0) return SAMPLE_W'($urandom_range(4095));
        if (above && gate_threshold != SAMPLE_MAX)
            return SAMPLE_W'($urandom_range(4095, gate_threshold + 1));
        return SAMPLE_W'($urandom_range(gate_threshold, 0));
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("Mismatch in %s at chunk result %0d: expected %0d, got %0d",
                     what, chunks_checked, want, got);
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && pop && empty === 1'b0) begin
            if (pending_chunks.size() == 0) begin
                report_mismatch("unexpected transaction, chunk_pulses", 0, 32'(o_chunk_pulses));
            end else begin
                want = pending_chunks.pop_front();
                if (o_chunk_pulses !== want.chunk_pulses)
                    report_mismatch("chunk_pulses", 32'(want.chunk_pulses),
                                    32'(o_chunk_pulses));
                if (o_window_done !== want.window_done)
                    report_mismatch("window_done", 32'(want.window_done), 32'(o_window_done));
                if (o_window_pulses !== want.window_pulses)
                    report_mismatch("window_pulses", 32'(want.window_pulses),
                                    32'(o_window_pulses));
                if (o_laser_enable !== want.laser_enable)
                    report_mismatch("laser_enable", 32'(want.laser_enable),
                                    32'(o_laser_enable));
            end
            chunks_checked++;
        end
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_chunks.size());
            $display("** pulse_count_laser_gate: FAILED **");
            $finish;
        end
    end

    // Reset settings: threshold edges, an open run dropped at chunk end, a run
    // ending on the last sample, and a full five-chunk window.
    task automatic test_threshold_edges();
        send_sample(12'd4001, 1'b0);
        send_sample(12'd4000, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample('0, 1'b0);
        send_sample(12'd4001, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample('0, 1'b1);
        repeat (3) send_sample(12'd3999, 1'b1);
    endtask

    // Laser off without tracking, then a decision and a window end on the same chunk.
    task automatic test_register_writes();
        apply_config(SAMPLE_MAX, 8'd2, 1'b1, 8'd1, 16'd1, 1'b0, '0);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MAX, 1'b1);
        apply_config('0, 8'd1, 1'b1, 8'd1, 16'd100, 1'b0, COUNT_MAX);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample('0, 1'b1);
    endtask

    // A window of 256 chunks, with an unreachable target at chunk 255 and
    // then a decision at chunk index zero.
    task automatic test_long_window();
        apply_config('0, 8'd0, 1'b1, 8'd255, COUNT_MAX, 1'b0, COUNT_MAX);
        align_window();
        repeat (256) send_sample(SAMPLE_MAX, 1'b1);
        apply_config('0, 8'd0, 1'b1, 8'd0, '0, 1'b1, '0);
        align_window();
        repeat (256) send_sample(SAMPLE_MAX, 1'b1);
    endtask

    task automatic test_random_traffic(input int unsigned n_items);
        logic [SAMPLE_W-1:0] thr;
        logic [INDEX_W-1:0]  cpw;
        logic [INDEX_W-1:0]  dch;
        logic [COUNT_W-1:0]  ppc;
        logic [COUNT_W-1:0]  tlim;
        int unsigned first;
        int unsigned len;
        repeat (3) begin
            case ($urandom_range(4))
                0: thr = '0;
                1: thr = SAMPLE_MAX;
                default: thr = SAMPLE_W'($urandom_range(4094, 1));
            endcase
            case ($urandom_range(7))
                0: cpw = 8'd1;
                1: cpw = 8'd255;
                2: cpw = 8'd0;
                default: cpw = INDEX_W'($urandom_range(6, 2));
            endcase
            case ($urandom_range(5))
                0: dch = 8'd0;
                1: dch = 8'd255;
                default: dch = INDEX_W'($urandom_range(4, 1));
            endcase
            case ($urandom_range(5))
                0: ppc = '0;
                1: ppc = COUNT_MAX;
                default: ppc = COUNT_W'($urandom_range(3, 1));
            endcase
            case ($urandom_range(5))
                0: tlim = '0;
                1: tlim = COUNT_MAX;
                default: tlim = COUNT_W'($urandom_range(4, 1));
            endcase
            apply_config(thr, cpw, $urandom_range(3) != 0, dch, ppc,
                         1'($urandom_range(1)), tlim);
            first = samples_sent;
            while (samples_sent - first < n_items / 3) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
                for (int k = 1; k <= len; k++)
                    send_sample(sample_level($urandom_range(99) < 45), k == len);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 9;
        recv_idle_pct = 45;
        test_threshold_edges();
        test_register_writes();
        test_random_traffic(90);

        send_idle_pct = 45;
        recv_idle_pct = 9;
        test_long_window();
        test_random_traffic(90);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(90);

        wait_idle();
        $display("Sent %0d samples; checked %0d chunk results, %0d closing a window, %0d laser off.",
                 samples_sent, chunks_checked, windows_closed, laser_off_chunks);
        $display("Covered threshold extremes, open runs at chunk ends and windows of 1 to 256 chunks.");
        if (mismatches == 0 && pending_chunks.size() == 0) begin
            $display("** pulse_count_laser_gate: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never seen.", mismatches, pending_chunks.size());
            $display("** pulse_count_laser_gate: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/plg_pkg.sv
rtl/plg_fifo.sv
rtl/plg_front.sv
rtl/plg_back.sv
rtl/pulse_count_laser_gate.sv
bench/testbench.sv
